// ----- rtl/aip_pkg.sv -----
// ============================================================================
// aip_pkg - shared types and constants of the ASCII integer parser
// Register indexes, status codes, character codes and the structs that carry
// a finished string and a result between the parser's stages.
// ============================================================================
package aip_pkg;

    // Sizes
    localparam int WORD_BITS = 64;
    localparam int MAX_LEN   = 4096;
    localparam int OFS_W     = $clog2(MAX_LEN + 1);
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOLLOWER_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_CHECK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX     = 3'd4;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OK_SIGN = 2'd1,
        ST_INVALID = 2'd2,
        ST_RANGE   = 2'd3
    } t_status;

    // Character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Configuration as seen by the parser
    typedef struct packed {
        logic                 signed_mode;
        logic                 follower_mode;
        logic                 range_check;
        logic [WORD_BITS-1:0] range_min;
        logic [WORD_BITS-1:0] range_max;
    } t_cfg;

    // Snapshot of the scanner at the final character of a string
    typedef struct packed {
        logic                 good;
        logic                 overflowed;
        logic                 negative;
        logic                 sign_seen;
        logic                 signed_mode;
        logic                 range_check;
        logic [WORD_BITS-1:0] acc;
        logic [OFS_W-1:0]     number_start;
        logic [OFS_W-1:0]     number_end;
    } t_fin;

    // One result beat
    typedef struct packed {
        t_status              status;
        logic [WORD_BITS-1:0] value;
        logic [OFS_W-1:0]     end_offset;
    } t_res;

    // Whitespace: space, tab, LF, VT, FF, CR
    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

// ----- rtl/ascii_integer_parser.sv -----
// ============================================================================
// ascii_integer_parser - text to 64-bit integer, one character per beat
// Parses decimal or 0x hex numbers with optional sign, underscores, leading
// and trailing whitespace, follower mode and an optional range check.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one character per beat;
//   i_last marks the final character of a string. Only that beat produces a
//   result on the output channel (o_out_valid / i_out_ready): status, value
//   and end offset. Other beats produce nothing.
//   Throughput is one character per cycle, back to back, while no last
//   character waits on a full snapshot register; the scanner's shift-add
//   of the accumulator is combinational. A result passes the input register,
//   scanner to snapshot register, status stage and range-check output register.
//   When the receiver stalls, results back up through the two result stages
//   and the snapshot register; characters that end no string keep flowing
//   until a last character finds the snapshot register full.
//   Configuration registers are written through i_cfg_we / i_cfg_index /
//   i_cfg_data with no wait; write them only while no string is in flight.
//   Reset (synchronous, active low) empties all stages, returns the scanner
//   to the start of a string and loads the register defaults: signed mode on,
//   follower mode and range check off, minimum zero, maximum all ones.
// ============================================================================
module ascii_integer_parser import aip_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // character channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_ch,
    input  logic                 i_last,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_status,
    output logic [WORD_BITS-1:0] o_value,
    output logic [OFS_W-1:0]     o_end_offset,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_BITS-1:0] i_cfg_data
);

    t_cfg r_cfg;

    logic       r_in_v;
    logic [7:0] r_ch;
    logic       r_last;

    logic r_fin_v;
    t_fin r_fin, n_fin;

    logic scan_fire, fin_ready, res_ready, res_valid;
    t_res res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.signed_mode   <= 1'b1;
            r_cfg.follower_mode <= 1'b0;
            r_cfg.range_check   <= 1'b0;
            r_cfg.range_min     <= '0;
            r_cfg.range_max     <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SIGNED_MODE:   r_cfg.signed_mode   <= i_cfg_data[0];
                CFG_FOLLOWER_MODE: r_cfg.follower_mode <= i_cfg_data[0];
                CFG_RANGE_CHECK:   r_cfg.range_check   <= i_cfg_data[0];
                CFG_RANGE_MIN:     r_cfg.range_min     <= i_cfg_data;
                CFG_RANGE_MAX:     r_cfg.range_max     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: a last character needs room in the snapshot register
    assign fin_ready  = !r_fin_v || res_ready;
    assign scan_fire  = r_in_v && (!r_last || fin_ready);
    assign o_in_ready = !r_in_v || scan_fire;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (o_in_ready) begin
            r_in_v <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_ch   <= i_ch;
            r_last <= i_last;
        end
    end

    aip_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (scan_fire),
        .i_ch    (r_ch),
        .i_last  (r_last),
        .i_cfg   (r_cfg),
        .o_fin   (n_fin)
    );

    // Snapshot register, loaded by the last character of a string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_v <= 1'b0;
        end else if (scan_fire && r_last) begin
            r_fin_v <= 1'b1;
        end else if (res_ready) begin
            r_fin_v <= 1'b0;
        end
        if (scan_fire && r_last) begin
            r_fin <= n_fin;
        end
    end

    aip_result u_result (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_fin_v),
        .o_ready     (res_ready),
        .i_fin       (r_fin),
        .i_range_min (r_cfg.range_min),
        .i_range_max (r_cfg.range_max),
        .o_valid     (res_valid),
        .i_ready     (i_out_ready),
        .o_res       (res)
    );

    assign o_out_valid  = res_valid;
    assign o_status     = 2'(res.status);
    assign o_value      = res.value;
    assign o_end_offset = res.end_offset;

endmodule

// ----- rtl/aip_scan.sv -----
// ============================================================================
// aip_scan - character scanner of the ASCII integer parser
// Walks the syntax one character per cycle while fired, keeps the accumulator with its
// overflow flag and the offsets, and presents the final snapshot of a string.
// ============================================================================
module aip_scan import aip_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    input  t_cfg       i_cfg,
    output t_fin       o_fin
);

    typedef enum logic [3:0] {
        PH_LEAD, PH_SIGN, PH_ZERO, PH_HEXPFX, PH_DIGITS,
        PH_UNDERS, PH_TRAIL, PH_JUNK, PH_BAD
    } t_phase;

    localparam logic [OFS_W-1:0] POS_SAT = OFS_W'(MAX_LEN);

    t_phase               r_phase, n_phase;
    logic [WORD_BITS-1:0] r_acc, n_acc;
    logic                 r_ovf, n_ovf;
    logic                 r_neg, n_neg;
    logic                 r_sign_seen, n_sign_seen;
    logic                 r_hex, n_hex;
    logic [OFS_W-1:0]     r_pos, r_start, n_start, r_end, n_end;

    logic             is_dec, is_hex_lo, is_hex_up, is_digit, is_sp, take;
    logic [3:0]       digit;
    logic [WORD_BITS+3:0] acc_ext, prod;
    logic [OFS_W-1:0] pos_next;

    // Character classes and digit value
    assign is_sp     = is_space(i_ch);
    assign is_dec    = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign is_hex_lo = r_hex && (i_ch >= CH_LO_A) && (i_ch <= CH_LO_F);
    assign is_hex_up = r_hex && (i_ch >= CH_UP_A) && (i_ch <= CH_UP_F);
    assign is_digit  = is_dec || is_hex_lo || is_hex_up;
    assign digit     = is_dec ? i_ch[3:0] : 4'(i_ch[3:0] + 4'd9);

    // Accumulate: acc * base + digit, overflow if anything lands above the word
    assign acc_ext = {4'b0, r_acc};
    assign prod    = r_hex ? ((acc_ext << 4) + {{WORD_BITS{1'b0}}, digit})
                           : ((acc_ext << 3) + (acc_ext << 1) + {{WORD_BITS{1'b0}}, digit});

    // Saturating character position
    assign pos_next = (r_pos >= POS_SAT) ? POS_SAT : r_pos + 1'b1;

    // Next-state logic
    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_ovf       = r_ovf;
        n_neg       = r_neg;
        n_sign_seen = r_sign_seen;
        n_hex       = r_hex;
        n_start     = r_start;
        n_end       = r_end;
        take        = 1'b0;

        unique case (r_phase)
            PH_LEAD: begin
                if (!is_sp) begin
                    n_start = r_pos;
                    if (i_cfg.signed_mode && ((i_ch == CH_PLUS) || (i_ch == CH_MINUS))) begin
                        n_sign_seen = 1'b1;
                        n_neg       = (i_ch == CH_MINUS);
                        n_phase     = PH_SIGN;
                    end else if (i_ch == CH_ZERO) begin
                        n_acc   = '0;
                        n_end   = pos_next;
                        n_phase = PH_ZERO;
                    end else if (is_digit) begin
                        take    = 1'b1;
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase = PH_BAD;
                    end
                end
            end
            PH_SIGN: begin
                if (!is_sp && (i_ch != CH_UNDER)) begin
                    if (i_ch == CH_ZERO) begin
                        n_acc   = '0;
                        n_end   = pos_next;
                        n_phase = PH_ZERO;
                    end else if (is_digit) begin
                        take    = 1'b1;
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase = PH_BAD;
                    end
                end
            end
            PH_ZERO, PH_DIGITS: begin
                if ((r_phase == PH_ZERO) && ((i_ch == CH_LO_X) || (i_ch == CH_UP_X))) begin
                    n_hex   = 1'b1;
                    n_phase = PH_HEXPFX;
                end else if (is_digit) begin
                    take    = 1'b1;
                    n_phase = PH_DIGITS;
                end else if (i_ch == CH_UNDER) begin
                    n_phase = PH_UNDERS;
                end else begin
                    n_phase = is_sp ? PH_TRAIL : PH_JUNK;
                end
            end
            PH_HEXPFX: begin
                if (i_ch != CH_UNDER) begin
                    if (is_digit) begin
                        take    = 1'b1;
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase = PH_BAD;
                    end
                end
            end
            PH_UNDERS: begin
                if (i_ch != CH_UNDER) begin
                    if (is_digit) begin
                        take    = 1'b1;
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase = PH_JUNK;
                    end
                end
            end
            PH_TRAIL: begin
                if (!is_sp) n_phase = PH_JUNK;
            end
            PH_JUNK, PH_BAD: begin
                n_phase = r_phase;
            end
            default: begin
                n_phase = PH_BAD;
            end
        endcase

        // Digit taken: accumulate unless already overflowed
        if (take) begin
            if (!r_ovf) begin
                if (|prod[WORD_BITS+3:WORD_BITS]) n_ovf = 1'b1;
                else                               n_acc = prod[WORD_BITS-1:0];
            end
            n_end = pos_next;
        end
    end

    // Final snapshot for the last character
    always_comb begin
        o_fin.good         = (n_phase == PH_ZERO) || (n_phase == PH_DIGITS) ||
                             (n_phase == PH_TRAIL) ||
                             (i_cfg.follower_mode &&
                              ((n_phase == PH_UNDERS) || (n_phase == PH_JUNK)));
        o_fin.overflowed   = n_ovf;
        o_fin.negative     = n_neg;
        o_fin.sign_seen    = n_sign_seen;
        o_fin.signed_mode  = i_cfg.signed_mode;
        o_fin.range_check  = i_cfg.range_check;
        o_fin.acc          = n_acc;
        o_fin.number_start = (n_phase == PH_LEAD) ? pos_next : n_start;
        o_fin.number_end   = n_end;
    end

    // Scanner state; cleared after the last character of each string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_last)) begin
            r_phase     <= PH_LEAD;
            r_acc       <= '0;
            r_ovf       <= 1'b0;
            r_neg       <= 1'b0;
            r_sign_seen <= 1'b0;
            r_hex       <= 1'b0;
            r_pos       <= '0;
            r_start     <= '0;
            r_end       <= '0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_acc       <= n_acc;
            r_ovf       <= n_ovf;
            r_neg       <= n_neg;
            r_sign_seen <= n_sign_seen;
            r_hex       <= n_hex;
            r_pos       <= pos_next;
            r_start     <= n_start;
            r_end       <= n_end;
        end
    end

endmodule

// ----- rtl/aip_result.sv -----
// ============================================================================
// aip_result - result stages of the ASCII integer parser
// First stage forms status, signed value and offset from the snapshot; the
// second applies the optional range check and holds the output beat.
// ============================================================================
module aip_result import aip_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_fin                 i_fin,
    input  logic [WORD_BITS-1:0] i_range_min,
    input  logic [WORD_BITS-1:0] i_range_max,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_res                 o_res
);

    localparam logic [WORD_BITS-1:0] TOP = {1'b1, {(WORD_BITS-1){1'b0}}};

    logic r_mid_v, r_out_v;
    t_res r_mid, n_mid, r_out, n_out;
    logic r_mid_sgn, r_mid_rc;
    logic mid_ready, out_ready;

    logic [WORD_BITS-1:0] v_b, lo_b, hi_b;

    assign out_ready = !r_out_v || i_ready;
    assign mid_ready = !r_mid_v || out_ready;
    assign o_ready   = mid_ready;

    // Status and value from the final accumulator
    always_comb begin
        n_mid.value = '0;
        priority if (!i_fin.good) begin
            n_mid.status = ST_INVALID;
        end else if (i_fin.overflowed) begin
            n_mid.status = ST_RANGE;
        end else if (!i_fin.signed_mode) begin
            n_mid.status = ST_OK;
            n_mid.value  = i_fin.acc;
        end else if (!i_fin.negative) begin
            n_mid.status = i_fin.sign_seen ? ST_OK_SIGN : ST_OK;
            if (!i_fin.acc[WORD_BITS-1]) n_mid.value  = i_fin.acc;
            else                         n_mid.status = ST_RANGE;
        end else begin
            n_mid.status = ST_OK_SIGN;
            if (!i_fin.acc[WORD_BITS-1] || (i_fin.acc == TOP)) n_mid.value = '0 - i_fin.acc;
            else                                                n_mid.status = ST_RANGE;
        end
        if ((n_mid.status == ST_INVALID) || (n_mid.status == ST_RANGE))
            n_mid.value = i_fin.signed_mode ? TOP : '0;
        n_mid.end_offset = (n_mid.status == ST_INVALID) ? i_fin.number_start
                                                        : i_fin.number_end;
    end

    // Range check: flip the sign bit in signed mode so unsigned order applies
    assign v_b  = {r_mid.value[WORD_BITS-1] ^ r_mid_sgn, r_mid.value[WORD_BITS-2:0]};
    assign lo_b = {i_range_min[WORD_BITS-1] ^ r_mid_sgn, i_range_min[WORD_BITS-2:0]};
    assign hi_b = {i_range_max[WORD_BITS-1] ^ r_mid_sgn, i_range_max[WORD_BITS-2:0]};

    always_comb begin
        n_out = r_mid;
        if (r_mid_rc) begin
            if ((r_mid.status == ST_INVALID) || (r_mid.status == ST_RANGE)) begin
                n_out.value = i_range_min;
            end else if ((v_b < lo_b) || (v_b > hi_b)) begin
                n_out.status = ST_RANGE;
                n_out.value  = i_range_min;
            end
        end
    end

    // Middle stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_v <= 1'b0;
        end else if (mid_ready) begin
            r_mid_v <= i_valid;
        end
        if (mid_ready && i_valid) begin
            r_mid     <= n_mid;
            r_mid_sgn <= i_fin.signed_mode;
            r_mid_rc  <= i_fin.range_check;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_ready) begin
            r_out_v <= r_mid_v;
        end
        if (out_ready && r_mid_v) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_v;
    assign o_res   = r_out;

endmodule

// ----- tb/ascii_integer_parser_test.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ascii_integer_parser_test - self-checking bench for the ASCII integer parser
// Streams strings one character per beat under many register settings and
// predicts each result with a behavioural scanner kept in step with the block.
// The bench compares status, value and end offset of every result beat.
// ============================================================================
module ascii_integer_parser_test;
    import aip_pkg::*;

    localparam logic [7:0]  CH_LF     = 8'h0A;
    localparam logic [7:0]  CH_VT     = 8'h0B;
    localparam logic [7:0]  CH_FF     = 8'h0C;
    localparam logic [63:0] WORD_MASK = '1;
    localparam logic [63:0] TOP_BIT   = 64'h8000_0000_0000_0000;

    typedef enum logic [3:0] {
        P_LEAD, P_SIGN, P_ZERO, P_HEXPFX, P_DIGITS, P_UNDERS, P_TRAIL, P_JUNK, P_BAD
    } t_scan_phase;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Block ports
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [7:0]           ch        = '0;
    logic                 last      = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [1:0]           dut_status;
    logic [WORD_BITS-1:0] dut_value;
    logic [OFS_W-1:0]     dut_offset;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [WORD_BITS-1:0] cfg_data  = '0;

    ascii_integer_parser u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_ch         (ch),
        .i_last       (last),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_status     (dut_status),
        .o_value      (dut_value),
        .o_end_offset (dut_offset),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_idx),
        .i_cfg_data   (cfg_data)
    );

    // Register copies, reset values
    logic        m_signed = 1'b1;
    logic        m_follow = 1'b0;
    logic        m_rcheck = 1'b0;
    logic [63:0] m_min    = '0;
    logic [63:0] m_max    = '1;

    // Scanner state of the predictor
    t_scan_phase      sc_phase = P_LEAD;
    logic [63:0]      sc_acc   = '0;
    logic             sc_ovf   = 1'b0;
    logic             sc_neg   = 1'b0;
    logic             sc_sign  = 1'b0;
    logic             sc_hex   = 1'b0;
    logic [OFS_W-1:0] sc_pos   = '0;
    logic [OFS_W-1:0] sc_start = '0;
    logic [OFS_W-1:0] sc_end   = '0;

    t_res       expected_results[$];
    logic [7:0] str_buf[$];
    bit         idle_en    = 1'b1;
    int         hold_left  = 0;
    int         n_chars    = 0;
    int         n_strings  = 0;
    int         n_results  = 0;
    int         n_settings = 0;
    int         n_errors   = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [OFS_W-1:0] step_pos(input logic [OFS_W-1:0] p);
        return (p >= OFS_W'(MAX_LEN)) ? OFS_W'(MAX_LEN) : p + 1'b1;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic digit_val(input logic [7:0] c, input logic hex,
                                       output logic [3:0] d);
        d = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = 4'(c - CH_ZERO);
            return 1'b1;
        end
        if (hex && c >= CH_LO_A && c <= CH_LO_F) begin
            d = 4'(c - CH_LO_A + 8'd10);
            return 1'b1;
        end
        if (hex && c >= CH_UP_A && c <= CH_UP_F) begin
            d = 4'(c - CH_UP_A + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Shift-add one digit; once past the word the accumulator freezes
    task automatic add_digit(input logic [3:0] d, input logic [OFS_W-1:0] p);
        logic [63:0] base;
        base = sc_hex ? 64'd16 : 64'd10;
        if (!sc_ovf) begin
            if (sc_acc > (WORD_MASK - 64'(d)) / base) sc_ovf = 1'b1;
            else sc_acc = sc_acc * base + 64'(d);
        end
        sc_end = step_pos(p);
    endtask

    task automatic start_number(input logic [7:0] c, input logic [OFS_W-1:0] p);
        logic [3:0] d;
        if (c == CH_ZERO) begin
            sc_acc   = '0;
            sc_end   = step_pos(p);
            sc_phase = P_ZERO;
        end else if (digit_val(c, sc_hex, d)) begin
            add_digit(d, p);
            sc_phase = P_DIGITS;
        end else begin
            sc_phase = P_BAD;
        end
    endtask

    // Advance the scanner by one character; on the last one queue the result
    task automatic predict_char(input logic [7:0] c, input logic is_last);
        logic [OFS_W-1:0] p;
        logic [3:0]       d;
        logic             again;
        logic             good;
        t_status          st;
        logic [63:0]      val, lo, hi, v;
        t_res             r;
        p     = sc_pos;
        again = 1'b1;
        while (again) begin
            again = 1'b0;
            case (sc_phase)
                P_LEAD: if (!is_blank(c)) begin
                    sc_start = p;
                    if (m_signed && (c == CH_PLUS || c == CH_MINUS)) begin
                        sc_sign  = 1'b1;
                        sc_neg   = (c == CH_MINUS);
                        sc_phase = P_SIGN;
                    end else begin
                        start_number(c, p);
                    end
                end
                P_SIGN: if (!is_blank(c) && c != CH_UNDER) start_number(c, p);
                P_ZERO: if (c == CH_LO_X || c == CH_UP_X) begin
                    sc_hex   = 1'b1;
                    sc_phase = P_HEXPFX;
                end else begin
                    // reconsider the same character as a decimal digit
                    sc_phase = P_DIGITS;
                    again    = 1'b1;
                end
                P_HEXPFX: if (c != CH_UNDER) begin
                    if (digit_val(c, sc_hex, d)) begin
                        add_digit(d, p);
                        sc_phase = P_DIGITS;
                    end else begin
                        sc_phase = P_BAD;
                    end
                end
                P_DIGITS: if (digit_val(c, sc_hex, d)) begin
                    add_digit(d, p);
                end else if (c == CH_UNDER) begin
                    sc_phase = P_UNDERS;
                end else begin
                    sc_phase = P_TRAIL;
                    again    = 1'b1;
                end
                P_UNDERS: if (c != CH_UNDER) begin
                    if (digit_val(c, sc_hex, d)) begin
                        add_digit(d, p);
                        sc_phase = P_DIGITS;
                    end else begin
                        sc_phase = P_JUNK;
                    end
                end
                P_TRAIL: if (!is_blank(c)) sc_phase = P_JUNK;
                default: ;
            endcase
        end
        sc_pos = step_pos(p);

        if (is_last) begin
            if (sc_phase == P_LEAD) sc_start = sc_pos;
            good = sc_phase == P_ZERO || sc_phase == P_DIGITS || sc_phase == P_TRAIL ||
                   (m_follow && (sc_phase == P_UNDERS || sc_phase == P_JUNK));
            val = '0;
            if (!good) begin
                st = ST_INVALID;
            end else if (sc_ovf) begin
                st = ST_RANGE;
            end else if (!m_signed) begin
                st  = ST_OK;
                val = sc_acc;
            end else if (!sc_neg) begin
                st = sc_sign ? ST_OK_SIGN : ST_OK;
                if (sc_acc < TOP_BIT) val = sc_acc;
                else st = ST_RANGE;
            end else begin
                st = ST_OK_SIGN;
                if (sc_acc <= TOP_BIT) val = 64'd0 - sc_acc;
                else st = ST_RANGE;
            end
            if (st == ST_INVALID || st == ST_RANGE) val = m_signed ? TOP_BIT : '0;

            // Bounds: biasing the sign bit turns signed order into unsigned order
            if (m_rcheck) begin
                lo = m_min;
                hi = m_max;
                if (st == ST_INVALID || st == ST_RANGE) begin
                    val = lo;
                end else begin
                    v = val;
                    if (m_signed) begin
                        lo[63] = ~lo[63];
                        hi[63] = ~hi[63];
                        v[63]  = ~v[63];
                    end
                    if (v < lo || v > hi) begin
                        st  = ST_RANGE;
                        val = m_min;
                    end
                end
            end

            r.status     = st;
            r.value      = val;
            r.end_offset = (st == ST_INVALID) ? sc_start : sc_end;
            expected_results.push_back(r);

            sc_phase = P_LEAD;
            sc_acc   = '0;
            sc_ovf   = 1'b0;
            sc_neg   = 1'b0;
            sc_sign  = 1'b0;
            sc_hex   = 1'b0;
            sc_pos   = '0;
            sc_start = '0;
            sc_end   = '0;
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure and comparison
    // ------------------------------------------------------------------
    always @(posedge clk) begin : result_check
        t_res exp_r;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing pending: status %0d value %0h offset %0d",
                           dut_status, dut_value, dut_offset);
                    n_errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (dut_status !== exp_r.status) begin
                        $error("status: expected %0d, got %0d", exp_r.status, dut_status);
                        n_errors++;
                    end
                    if (dut_value !== exp_r.value) begin
                        $error("value: expected %0h, got %0h", exp_r.value, dut_value);
                        n_errors++;
                    end
                    if (dut_offset !== exp_r.end_offset) begin
                        $error("end_offset: expected %0d, got %0d", exp_r.end_offset,
                               dut_offset);
                        n_errors++;
                    end
                    n_results++;
                end
                hold_left = idle_en ? $urandom_range(0, 5) : 0;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Character side
    // ------------------------------------------------------------------
    // Called at a rising edge; returns at the edge that takes the beat
    task automatic send_char(input logic [7:0] c, input logic is_last);
        int gap;
        gap = idle_en ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        ch       <= c;
        last     <= is_last;
        do @(posedge clk); while (!in_ready);
        predict_char(c, is_last);
        n_chars++;
    endtask

    task automatic send_string();
        foreach (str_buf[i]) send_char(str_buf[i], i == str_buf.size() - 1);
        n_strings++;
    endtask

    task automatic load_text(input string s);
        str_buf.delete();
        for (int i = 0; i < s.len(); i++) str_buf.push_back(s[i]);
    endtask

    function automatic logic [7:0] pick_ws();
        case ($urandom_range(0, 5))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            3:       return CH_VT;
            4:       return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    // Mostly well-formed numbers with random content; some noise and damage
    task automatic gen_string();
        logic [63:0] mag;
        logic [63:0] base;
        int          kind;
        bit          hex;
        bit          upper;
        int          digs[$];
        int          d;
        str_buf.delete();
        if ($urandom_range(0, 99) < 12) begin
            repeat ($urandom_range(1, 6)) str_buf.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 2)) str_buf.push_back(pick_ws());
        if ($urandom_range(0, 2) == 0) begin
            str_buf.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
            repeat ($urandom_range(0, 2))
                str_buf.push_back($urandom_range(0, 2) == 0 ? CH_UNDER : pick_ws());
        end

        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3: mag = 64'($urandom_range(0, 999));
            4, 5: case ($urandom_range(0, 6))
                0:       mag = '0;
                1:       mag = 64'd1;
                2:       mag = 64'h7FFF_FFFF_FFFF_FFFF;
                3:       mag = TOP_BIT;
                4:       mag = 64'h8000_0000_0000_0001;
                5:       mag = '1;
                default: mag = 64'h1_0000_0000;
            endcase
            8:       mag = 64'($urandom);
            default: mag = {$urandom, $urandom};
        endcase

        hex  = $urandom_range(0, 2) == 0;
        base = hex ? 64'd16 : 64'd10;
        do begin
            digs.push_front(int'(mag % base));
            mag = mag / base;
        end while (mag != 0);
        // extra digits push a large value past the word
        if (kind == 9) repeat ($urandom_range(1, 3))
            digs.push_back($urandom_range(0, int'(base) - 1));
        if (!hex && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 2)) digs.push_front(0);

        if (hex) begin
            str_buf.push_back(CH_ZERO);
            str_buf.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
            if ($urandom_range(0, 3) == 0) str_buf.push_back(CH_UNDER);
        end
        upper = $urandom_range(0, 1);
        foreach (digs[i]) begin
            if (i > 0 && $urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 2)) str_buf.push_back(CH_UNDER);
            d = digs[i];
            str_buf.push_back(d < 10 ? CH_ZERO + 8'(d) :
                              (upper ? CH_UP_A : CH_LO_A) + 8'(d - 10));
        end

        // tail: trailing underscores, following text, or whitespace
        case ($urandom_range(0, 9))
            0: repeat ($urandom_range(1, 2)) str_buf.push_back(CH_UNDER);
            1, 2: begin
                str_buf.push_back(8'($urandom_range(8'h67, 8'h7A)));
                repeat ($urandom_range(0, 3)) str_buf.push_back(8'($urandom_range(0, 255)));
            end
            default: repeat ($urandom_range(0, 2)) str_buf.push_back(pick_ws());
        endcase

        if ($urandom_range(0, 9) == 0)
            str_buf[$urandom_range(0, str_buf.size() - 1)] = 8'($urandom_range(0, 255));
    endtask

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_SIGNED_MODE:   m_signed = data[0];
            CFG_FOLLOWER_MODE: m_follow = data[0];
            CFG_RANGE_CHECK:   m_rcheck = data[0];
            CFG_RANGE_MIN:     m_min    = data;
            CFG_RANGE_MAX:     m_max    = data;
            default: ;
        endcase
    endtask

    // Drain every pending result, then allow the pipeline to empty
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_config(input logic sgn, input logic fol, input logic rc,
                              input logic [63:0] lo, input logic [63:0] hi);
        settle();
        write_reg(CFG_SIGNED_MODE, 64'(sgn));
        write_reg(CFG_FOLLOWER_MODE, 64'(fol));
        write_reg(CFG_RANGE_CHECK, 64'(rc));
        write_reg(CFG_RANGE_MIN, lo);
        write_reg(CFG_RANGE_MAX, hi);
        n_settings++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Short strings under reset settings: byte extremes, hex prefix forms,
    // trailing underscores, sign with gap, whitespace only, following junk
    task automatic test_directed_strings();
        idle_en = 1'b1;
        load_text("0");     send_string();
        load_text("0x_a");  send_string();
        load_text("0X");    send_string();
        load_text("1__");   send_string();
        load_text("- _5 "); send_string();
        load_text("\t");    send_string();
        load_text("7a");    send_string();
        str_buf = '{8'hFF}; send_string();
        str_buf = '{8'h00}; send_string();
    endtask

    // Random strings across mode combinations and bound windows
    task automatic test_register_sweep();
        logic [63:0] lo, hi;
        logic        sgn, rc;
        int          budget;
        for (int k = 0; k < 10; k++) begin
            sgn = k[0];
            rc  = (k < 8) ? k[2] : 1'($urandom_range(0, 1));
            case (k % 4)
                0: begin lo = '0; hi = '1; end
                1: begin lo = TOP_BIT; hi = 64'h7FFF_FFFF_FFFF_FFFF; end
                2: begin
                    lo = sgn ? 64'd0 - 64'($urandom_range(0, 500)) : 64'($urandom_range(0, 300));
                    hi = 64'($urandom_range(0, 800));
                end
                default: begin lo = {$urandom, $urandom}; hi = {$urandom, $urandom}; end
            endcase
            idle_en = (k % 3) != 0;
            set_config(sgn, k[1], rc, lo, hi);
            budget = n_chars + 90;
            while (n_chars < budget) begin
                gen_string();
                send_string();
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_strings();
        test_register_sweep();
        settle();
        $display("Parsed %0d strings (%0d characters) under %0d register settings;",
                 n_strings, n_chars, n_settings);
        $display("%0d results checked, %0d mismatches.", n_results, n_errors);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/aip_pkg.sv
rtl/aip_scan.sv
rtl/aip_result.sv
rtl/ascii_integer_parser.sv
tb/ascii_integer_parser_test.sv
